// File: design/elcsr_pkg.sv
`timescale 1ns / 1ps

package elcsr_pkg;

	localparam int ACTION_W   = 3;
	localparam int VERTEX_W   = 10;
	localparam int INDEX_W    = 13;
	localparam int VALUE_W    = 14;
	localparam int STATUS_W   = 3;
	localparam int TOTAL_W    = 13;
	localparam int VCOUNT_W   = 11;

	localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_BUILD    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_RD_OFF   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RD_NBR   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_VERT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 3'd4;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
		logic [INDEX_W-1:0]  read_index;
	} cmd_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic [STATUS_W-1:0] status;
		logic [TOTAL_W-1:0]  edge_total;
	} rsp_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_READ,
		S_CLR,
		S_CNT_RE,
		S_CNT_RA,
		S_CNT_WA,
		S_CNT_RB,
		S_CNT_WB,
		S_PFX_RD,
		S_PFX_WR,
		S_SC_RE,
		S_SC_RA,
		S_SC_WA,
		S_SC_RB,
		S_SC_WB,
		S_RESP
	} state_t;

endpackage

// File: design/edge_list_to_csr_builder.sv
`timescale 1ns / 1ps

// Channel  | Valid      | Stall      | Payload
// command  | cmd_valid  | cmd_stall  | cmd (cmd_item_t)
// response | rsp_valid  | rsp_stall  | rsp (rsp_item_t)
// config   | cfg_we     | -          | cfg_data (vertex count)
//
// Add, clear and idle actions go straight to S_RESP; reads that pass their
// checks take one memory read in S_READ first. Build walks the vertices and
// edges: a fill-count clear, counting, prefix sum, a second clear and scatter,
// all sequenced through the single read and write port of each memory.
// One command is in flight at a time; cmd_stall is high until its response
// sits in the output register. arst_n clears control state only.
// A held rsp_stall holds the response; the next command runs but waits in S_RESP.
module edge_list_to_csr_builder import elcsr_pkg::*; #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cmd_item_t           cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_item_t           rsp,
	input  logic                cfg_we,
	input  logic [VCOUNT_W-1:0] cfg_data
);

	localparam int SLOT_DEPTH = 2 * MAX_EDGES;
	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int OAW = $clog2(MAX_VERTICES + 1);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int LW  = $clog2(MAX_EDGES + 1);
	localparam int SW  = $clog2(SLOT_DEPTH);
	localparam int CW  = $clog2(SLOT_DEPTH + 1);
	localparam logic [VCOUNT_W-1:0] VT_MAX =
		VCOUNT_W'((MAX_VERTICES < 2047) ? MAX_VERTICES : 2047);
	localparam logic [VCOUNT_W-1:0] VT_RESET =
		VCOUNT_W'((MAX_VERTICES < 1024) ? MAX_VERTICES : 1024);

	// memories
	logic [VERTEX_W-1:0] edge_a_mem [MAX_EDGES];
	logic [VERTEX_W-1:0] edge_b_mem [MAX_EDGES];
	logic [CW-1:0]       fill_mem   [MAX_VERTICES];
	logic [CW-1:0]       off_mem    [MAX_VERTICES + 1];
	logic [VERTEX_W-1:0] nbr_mem    [SLOT_DEPTH];

	logic [EAW-1:0]      edge_raddr, edge_waddr;
	logic                edge_we;
	logic [VERTEX_W-1:0] edge_a_rd, edge_b_rd;
	logic [VAW-1:0]      fill_raddr, fill_waddr;
	logic                fill_we;
	logic [CW-1:0]       fill_wdata, fill_rd;
	logic [OAW-1:0]      off_raddr, off_waddr;
	logic                off_we;
	logic [CW-1:0]       off_wdata, off_rd;
	logic [SW-1:0]       nbr_raddr, nbr_waddr;
	logic                nbr_we;
	logic [VERTEX_W-1:0] nbr_wdata, nbr_rd;

	state_t state_q, state_d;
	logic [VCOUNT_W-1:0] vt_q;
	logic                built_q;
	logic [LW-1:0]       loaded_q;
	logic [CW-1:0]       final_q, sum_q;
	logic [VCW-1:0]      v_q;
	logic [LW-1:0]       e_q;
	logic [VERTEX_W-1:0] a_q, b_q;
	logic                phase_q;
	logic                rsel_q;
	logic [VALUE_W-1:0]  res_value_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                rsp_valid_q;
	rsp_item_t           rsp_q;

	logic accept, rsp_free, pair_bad, full, off_ok, nbr_ok;
	logic e_last, v_last, edge_bad, slot_ok;
	logic [31:0] slot, psum;
	logic [CW-1:0] fill_inc;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pair_bad = (32'(cmd.vertex_a) >= 32'(vt_q)) || (32'(cmd.vertex_b) >= 32'(vt_q));
	assign full     = 32'(loaded_q) >= MAX_EDGES;
	assign off_ok   = 32'(cmd.read_index) <= 32'(vt_q);
	assign nbr_ok   = (32'(cmd.read_index) < 32'(final_q))
		&& (32'(cmd.read_index) < SLOT_DEPTH);
	assign e_last   = (32'(e_q) + 32'd1) == 32'(loaded_q);
	assign v_last   = (32'(v_q) + 32'd1) == 32'(vt_q);
	assign edge_bad = (32'(edge_a_rd) >= 32'(vt_q)) || (32'(edge_b_rd) >= 32'(vt_q));
	assign slot     = 32'(off_rd) + 32'(fill_rd);
	assign slot_ok  = slot < SLOT_DEPTH;
	assign fill_inc = fill_rd + CW'(1);
	assign psum     = 32'(sum_q) + 32'(fill_rd);

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_a_mem[edge_waddr] <= cmd.vertex_a;
			edge_b_mem[edge_waddr] <= cmd.vertex_b;
		end
		edge_a_rd <= edge_a_mem[edge_raddr];
		edge_b_rd <= edge_b_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		fill_rd <= fill_mem[fill_raddr];
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_waddr] <= off_wdata;
		end
		off_rd <= off_mem[off_raddr];
	end

	always_ff @(posedge clk) begin
		if (nbr_we) begin
			nbr_mem[nbr_waddr] <= nbr_wdata;
		end
		nbr_rd <= nbr_mem[nbr_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.action)
						ACT_BUILD:  state_d = S_CLR;
						ACT_RD_OFF: state_d = (built_q && off_ok) ? S_READ : S_RESP;
						ACT_RD_NBR: state_d = (built_q && nbr_ok) ? S_READ : S_RESP;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_READ: state_d = S_RESP;
			S_CLR: begin
				if (v_last) begin
					if (loaded_q == '0) begin
						state_d = phase_q ? S_RESP : S_PFX_RD;
					end else begin
						state_d = phase_q ? S_SC_RE : S_CNT_RE;
					end
				end
			end
			S_CNT_RE: state_d = S_CNT_RA;
			S_CNT_RA: begin
				if (!edge_bad) begin
					state_d = S_CNT_WA;
				end else begin
					state_d = e_last ? S_PFX_RD : S_CNT_RE;
				end
			end
			S_CNT_WA: state_d = S_CNT_RB;
			S_CNT_RB: state_d = S_CNT_WB;
			S_CNT_WB: state_d = e_last ? S_PFX_RD : S_CNT_RE;
			S_PFX_RD: state_d = S_PFX_WR;
			S_PFX_WR: state_d = v_last ? S_CLR : S_PFX_RD;
			S_SC_RE:  state_d = S_SC_RA;
			S_SC_RA: begin
				if (!edge_bad) begin
					state_d = S_SC_WA;
				end else begin
					state_d = e_last ? S_RESP : S_SC_RE;
				end
			end
			S_SC_WA: state_d = S_SC_RB;
			S_SC_RB: state_d = S_SC_WB;
			S_SC_WB: state_d = e_last ? S_RESP : S_SC_RE;
			S_RESP:  state_d = rsp_free ? S_IDLE : S_RESP;
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		edge_raddr = e_q[EAW-1:0];
		edge_waddr = loaded_q[EAW-1:0];
		edge_we    = 1'b0;
		fill_raddr = v_q[VAW-1:0];
		fill_waddr = v_q[VAW-1:0];
		fill_we    = 1'b0;
		fill_wdata = '0;
		off_raddr  = OAW'(32'(cmd.read_index));
		off_waddr  = '0;
		off_we     = 1'b0;
		off_wdata  = '0;
		nbr_raddr  = SW'(32'(cmd.read_index));
		nbr_waddr  = slot[SW-1:0];
		nbr_we     = 1'b0;
		nbr_wdata  = b_q;
		case (state_q)
			S_IDLE: begin
				edge_we = accept && (cmd.action == ACT_ADD) && !pair_bad && !full;
			end
			S_CLR: begin
				fill_we = 1'b1;
				off_we  = !phase_q && (v_q == '0);
			end
			S_CNT_RA: begin
				fill_raddr = VAW'(32'(edge_a_rd));
			end
			S_CNT_WA: begin
				fill_we    = 1'b1;
				fill_waddr = VAW'(32'(a_q));
				fill_wdata = fill_inc;
			end
			S_CNT_RB: begin
				fill_raddr = VAW'(32'(b_q));
			end
			S_CNT_WB: begin
				fill_we    = 1'b1;
				fill_waddr = VAW'(32'(b_q));
				fill_wdata = fill_inc;
			end
			S_PFX_WR: begin
				off_we    = 1'b1;
				off_waddr = OAW'(32'(v_q) + 32'd1);
				off_wdata = psum[CW-1:0];
			end
			S_SC_RA: begin
				fill_raddr = VAW'(32'(edge_a_rd));
				off_raddr  = OAW'(32'(edge_a_rd));
			end
			S_SC_WA: begin
				fill_we    = 1'b1;
				fill_waddr = VAW'(32'(a_q));
				fill_wdata = fill_inc;
				nbr_we     = slot_ok;
				nbr_wdata  = b_q;
			end
			S_SC_RB: begin
				fill_raddr = VAW'(32'(b_q));
				off_raddr  = OAW'(32'(b_q));
			end
			S_SC_WB: begin
				fill_we    = 1'b1;
				fill_waddr = VAW'(32'(b_q));
				fill_wdata = fill_inc;
				nbr_we     = slot_ok;
				nbr_wdata  = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vt_q         <= VT_RESET;
			built_q      <= 1'b0;
			loaded_q     <= '0;
			final_q      <= '0;
			sum_q        <= '0;
			v_q          <= '0;
			e_q          <= '0;
			a_q          <= '0;
			b_q          <= '0;
			phase_q      <= 1'b0;
			rsel_q       <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_data == '0) begin
					vt_q <= VCOUNT_W'(1);
				end else if (cfg_data > VT_MAX) begin
					vt_q <= VT_MAX;
				end else begin
					vt_q <= cfg_data;
				end
				built_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_value_q  <= '0;
						res_status_q <= ST_OK;
						v_q          <= '0;
						e_q          <= '0;
						phase_q      <= 1'b0;
						rsel_q       <= (cmd.action == ACT_RD_NBR);
						case (cmd.action)
							ACT_ADD: begin
								if (pair_bad) begin
									res_status_q <= ST_BAD_VERT;
								end else if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									loaded_q <= loaded_q + LW'(1);
									built_q  <= 1'b0;
								end
							end
							ACT_RD_OFF: begin
								if (!built_q) begin
									res_status_q <= ST_NOT_BUILT;
								end else if (!off_ok) begin
									res_status_q <= ST_BAD_INDEX;
								end
							end
							ACT_RD_NBR: begin
								if (!built_q) begin
									res_status_q <= ST_NOT_BUILT;
								end else if (!nbr_ok) begin
									res_status_q <= ST_BAD_INDEX;
								end
							end
							ACT_CLEAR: begin
								loaded_q <= '0;
								built_q  <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					res_value_q <= rsel_q ? VALUE_W'(32'(nbr_rd)) : VALUE_W'(32'(off_rd));
				end
				S_CLR: begin
					v_q <= v_last ? '0 : v_q + VCW'(1);
					sum_q <= '0;
					if (v_last && phase_q && (loaded_q == '0)) begin
						built_q <= 1'b1;
					end
				end
				S_CNT_RA, S_SC_RA: begin
					a_q <= edge_a_rd;
					b_q <= edge_b_rd;
					if (edge_bad) begin
						e_q <= e_q + LW'(1);
						if (e_last && (state_q == S_SC_RA)) begin
							built_q <= 1'b1;
						end
					end
				end
				S_CNT_WB, S_SC_WB: begin
					e_q <= e_q + LW'(1);
					if (e_last && (state_q == S_SC_WB)) begin
						built_q <= 1'b1;
					end
				end
				S_PFX_WR: begin
					sum_q <= psum[CW-1:0];
					if (v_last) begin
						final_q <= psum[CW-1:0];
						phase_q <= 1'b1;
						v_q     <= '0;
						e_q     <= '0;
					end else begin
						v_q <= v_q + VCW'(1);
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && rsp_free) begin
			rsp_q.read_value <= res_value_q;
			rsp_q.status     <= res_status_q;
			rsp_q.edge_total <= TOTAL_W'(32'(loaded_q));
		end
	end

endmodule
